// ===== hdl/speculative_dfa_stream_matcher_top_macros.svh =====
// Assertion helpers shared by the matcher RTL
`ifndef SPECULATIVE_DFA_STREAM_MATCHER_TOP_MACROS_SVH
`define SPECULATIVE_DFA_STREAM_MATCHER_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset
`define SDM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent
`define SDM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hdl/sdm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdm_pkg
// Shared types and constants for the speculative DFA stream matcher.
// ----------------------------------------------------------------------------
package sdm_pkg;
   localparam int STATES_DEF  = 256;
   localparam int CLASSES_DEF = 64;
   localparam int LANES_DEF   = 16;
   localparam int KIND_W  = 3;
   localparam int STATE_W = 8;
   localparam int CLASS_W = 6;
   localparam int LANE_W  = 4;
   localparam int BYTE_W  = 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD_TRANS = 3'd0,
      KIND_LOAD_CLASS = 3'd1,
      KIND_LOAD_GUESS = 3'd2,
      KIND_BLOCK_START = 3'd3,
      KIND_PAIR       = 3'd4,
      KIND_SINGLE     = 3'd5
   } kind_type;

   // request after class lookup, handed from front to back
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [STATE_W-1:0] index_state;
      logic [CLASS_W-1:0] class_a;
      logic [CLASS_W-1:0] class_b;
      logic [LANE_W-1:0]  lane;
      logic [STATE_W-1:0] value_state;
      logic [CLASS_W-1:0] cls_first;
      logic [CLASS_W-1:0] cls_second;
      logic               block_end;
   } op_type;

   typedef struct packed {
      logic [STATE_W-1:0] state_out;
      logic               spec_hit;
      logic [LANE_W-1:0]  hit_lane;
   } rsp_type;
endpackage

// ===== hdl/sdm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdm_req_if / sdm_rsp_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface sdm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] index_state;
   logic [5:0] class_a;
   logic [5:0] class_b;
   logic [3:0] lane;
   logic [7:0] value_state;
   logic [7:0] byte_value;
   logic [7:0] sym_first;
   logic [7:0] sym_second;
   logic       block_end;
   modport source (output valid, kind, index_state, class_a, class_b, lane, value_state,
                   byte_value, sym_first, sym_second, block_end, input ready);
   modport sink (input valid, kind, index_state, class_a, class_b, lane, value_state,
                 byte_value, sym_first, sym_second, block_end, output ready);
endinterface

interface sdm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] state_out;
   logic       spec_hit;
   logic [3:0] hit_lane;
   modport source (output valid, state_out, spec_hit, hit_lane, input ready);
   modport sink (input valid, state_out, spec_hit, hit_lane, output ready);
endinterface

// ===== hdl/speculative_dfa_stream_matcher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// speculative_dfa_stream_matcher_top
// Table-driven DFA stepping a true lane and speculative guess lanes.
// ----------------------------------------------------------------------------
// Each request passes the lane engine in a read phase, which reads the per-lane
// transition and guess memory banks, then an exec phase, which updates the lane
// registers, since the next step's address depends on the state just read.
// Class lookup runs a stage ahead in the front and a four-entry queue lets the
// front keep accepting while the engine or the response side stalls. Class map
// loads finish in the front. No clearing pass after reset.
module speculative_dfa_stream_matcher_top #(
   parameter int STATES  = sdm_pkg::STATES_DEF,
   parameter int CLASSES = sdm_pkg::CLASSES_DEF,
   parameter int LANES   = sdm_pkg::LANES_DEF
) (
   input logic       clock,
   input logic       reset,
   sdm_req_if.sink   req,
   sdm_rsp_if.source rsp
);
   import sdm_pkg::*;

   logic   f_valid, f_ready, q_valid, q_ready;
   op_type f_data, q_data;

   sdm_front u_front (
      .clock, .reset, .req,
      .op_valid(f_valid), .op_data(f_data), .op_ready(f_ready)
   );

   sdm_queue #(.DEPTH(4)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_data(f_data), .in_ready(f_ready),
      .out_valid(q_valid), .out_data(q_data), .out_ready(q_ready)
   );

   sdm_back #(.STATES(STATES), .CLASSES(CLASSES), .LANES(LANES)) u_back (
      .clock, .reset,
      .op_valid(q_valid), .op_data(q_data), .op_ready(q_ready), .rsp
   );
endmodule

// ===== hdl/sdm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdm_front
// Accepts requests, owns the class map, maps symbols to classes.
// ----------------------------------------------------------------------------
module sdm_front (
   input  logic           clock,
   input  logic           reset,
   sdm_req_if.sink        req,
   output logic           op_valid,
   output sdm_pkg::op_type op_data,
   input  logic           op_ready
);
   import sdm_pkg::*;

   logic [CLASS_W-1:0] class_mem [256];
   logic               stage_valid_ff, stage_valid_in;
   op_type             stage_ff;
   logic               take;

   // stage is free when empty or draining this cycle
   assign req.ready = !stage_valid_ff || op_ready;
   assign take      = req.valid && req.ready;

   // class map: written by loads, read for symbols
   always_ff @(posedge clock) begin
      if (take && req.kind == KIND_LOAD_CLASS) begin
         class_mem[req.byte_value] <= req.class_a;
      end
   end

   // one registered stage; class lookups happen on its input
   always_ff @(posedge clock) begin
      if (take) begin
         stage_ff.kind        <= req.kind;
         stage_ff.index_state <= req.index_state;
         stage_ff.class_a     <= req.class_a;
         stage_ff.class_b     <= req.class_b;
         stage_ff.lane        <= req.lane;
         stage_ff.value_state <= req.value_state;
         stage_ff.cls_first   <= class_mem[req.sym_first];
         stage_ff.cls_second  <= class_mem[req.sym_second];
         stage_ff.block_end   <= req.block_end;
      end
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (op_ready) stage_valid_in = 1'b0;
      if (take && req.kind != KIND_LOAD_CLASS) stage_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   assign op_valid = stage_valid_ff;
   assign op_data  = stage_ff;
endmodule

// ===== hdl/sdm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdm_queue
// Small FIFO decoupling the front from the back.
// ----------------------------------------------------------------------------
module sdm_queue #(
   parameter int DEPTH = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  sdm_pkg::op_type in_data,
   output logic            in_ready,
   output logic            out_valid,
   output sdm_pkg::op_type out_data,
   input  logic            out_ready
);
   import sdm_pkg::*;
   `include "speculative_dfa_stream_matcher_top_macros.svh"

   localparam int PW = $clog2(DEPTH);
   op_type            mem_ff [DEPTH];
   logic [PW-1:0]     wr_ff, rd_ff;
   logic [PW:0]       cnt_ff;
   logic              push, pop;

   assign in_ready  = cnt_ff != DEPTH[PW:0];
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_data;
   end

   // pointers wrap at DEPTH
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

   `SDM_ASSERT_IMP(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= DEPTH[PW:0], "queue overfill")
   `SDM_ASSERT_NEXT(a_push_only, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 1'b1,
      "count missed push")
   `SDM_ASSERT_NEXT(a_pop_only, clock, reset, pop && !push, cnt_ff == $past(cnt_ff) - 1'b1,
      "count missed pop")
endmodule

// ===== hdl/sdm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdm_back
// Lane engine: transition and guess memories, lane registers, match logic.
// Each step reads memories in the read phase and updates lanes in the exec phase.
// ----------------------------------------------------------------------------
module sdm_back #(
   parameter int STATES  = sdm_pkg::STATES_DEF,
   parameter int CLASSES = sdm_pkg::CLASSES_DEF,
   parameter int LANES   = sdm_pkg::LANES_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            op_valid,
   input  sdm_pkg::op_type op_data,
   output logic            op_ready,
   sdm_rsp_if.source       rsp
);
   import sdm_pkg::*;
   `include "speculative_dfa_stream_matcher_top_macros.svh"

   localparam int SW = $clog2(STATES);
   localparam int CW = $clog2(CLASSES);
   localparam int LW = $clog2(LANES);
   localparam int TD = STATES * CLASSES;
   localparam int GD = CLASSES * CLASSES;

   typedef enum logic [1:0] {
      ST_READ = 2'b01,
      ST_EXEC = 2'b10
   } phase_type;

   phase_type           phase_ff, phase_in;
   op_type              cur_ff;
   logic [STATE_W-1:0]  true_ff, true_in;
   logic [STATE_W-1:0]  start_ff [LANES];
   logic [STATE_W-1:0]  lstate_ff [LANES];
   logic [STATE_W-1:0]  rd_data [LANES];
   logic [STATE_W-1:0]  trans_rd [LANES];
   logic [STATE_W-1:0]  guess_rd [LANES];
   logic                rvalid_ff;
   rsp_type             rsp_ff;
   logic                out_free, go, exec, emit;
   logic                st_ok_q, cl_ok_q;

   assign out_free = !rvalid_ff || rsp.ready;
   assign op_ready = phase_ff == ST_READ;
   assign go   = op_valid && op_ready;
   assign exec = phase_ff == ST_EXEC;

   always_comb begin
      phase_in = phase_ff;
      if (go) phase_in = ST_EXEC;
      else if (exec && out_free) phase_in = ST_READ;
   end

   always_ff @(posedge clock) begin
      if (go) cur_ff <= op_data;
   end

   // per-lane banks of the transition table and guess table
   for (genvar j = 0; j < LANES; j++) begin : g_lane
      logic [STATE_W-1:0]    tmem [TD];
      logic [STATE_W-1:0]    gmem [GD];
      logic [STATE_W-1:0]    trans_rd_ff;
      logic [STATE_W-1:0]    guess_rd_ff;
      logic [SW-1:0]         src;
      logic [CW-1:0]         cls;
      logic [$clog2(GD)-1:0] ga;
      always_comb begin
         src = (j == 0) ? ((op_data.kind == KIND_SINGLE) ? true_in[SW-1:0]
                                                         : lstate_ff[j][SW-1:0])
                        : lstate_ff[j][SW-1:0];
         cls = (j == 0) ? op_data.cls_first[CW-1:0] : op_data.cls_second[CW-1:0];
         ga  = {op_data.cls_first[CW-1:0], op_data.cls_second[CW-1:0]};
      end
      always_ff @(posedge clock) begin
         if (go && op_data.kind == KIND_LOAD_TRANS
             && 32'(op_data.class_a) < CLASSES && 32'(op_data.index_state) < STATES) begin
            tmem[{op_data.class_a[CW-1:0], op_data.index_state[SW-1:0]}]
               <= op_data.value_state;
         end
         if (go && op_data.kind == KIND_LOAD_GUESS && 32'(op_data.lane) == j && j != 0
             && 32'(op_data.class_a) < CLASSES && 32'(op_data.class_b) < CLASSES) begin
            gmem[{op_data.class_a[CW-1:0], op_data.class_b[CW-1:0]}] <= op_data.value_state;
         end
         if (go) begin
            trans_rd_ff <= tmem[{cls, src}];
            guess_rd_ff <= gmem[ga];
         end
      end
      assign trans_rd[j] = trans_rd_ff;
      assign guess_rd[j] = guess_rd_ff;
   end

   // range checks of the read request (fields wider than the tables)
   always_ff @(posedge clock) begin
      if (go) begin
         st_ok_q <= 32'(op_data.cls_first) < CLASSES;
         cl_ok_q <= 32'(op_data.cls_second) < CLASSES;
      end
   end

   // lowest matching guess lane
   logic [LW-1:0] hit_idx;
   logic          hit_any;
   always_comb begin
      rd_data[0] = (st_ok_q && 32'(lstate_ff[0]) < STATES) ? trans_rd[0] : '0;
      for (int j = 1; j < LANES; j++)
         rd_data[j] = (cl_ok_q && 32'(lstate_ff[j]) < STATES) ? trans_rd[j] : '0;
      hit_any = 1'b0;
      hit_idx = '0;
      for (int j = LANES - 1; j >= 1; j--) begin
         if (start_ff[j] == rd_data[0]) begin
            hit_any = 1'b1;
            hit_idx = LW'(j);
         end
      end
   end

   assign emit = exec && out_free &&
      ((cur_ff.kind == KIND_PAIR && cur_ff.block_end) || cur_ff.kind == KIND_SINGLE);

   always_comb begin
      true_in = true_ff;
      if (exec && out_free) begin
         if (cur_ff.kind == KIND_SINGLE)
            true_in = (st_ok_q && 32'(true_ff) < STATES) ? trans_rd[0] : '0;
         else if (cur_ff.kind == KIND_PAIR && cur_ff.block_end)
            true_in = hit_any ? rd_data[hit_idx] : rd_data[0];
      end
   end

   // lane registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= ST_READ;
         true_ff   <= '0;
         rvalid_ff <= 1'b0;
         for (int j = 0; j < LANES; j++) begin
            start_ff[j]  <= '0;
            lstate_ff[j] <= '0;
         end
      end else begin
         phase_ff  <= phase_in;
         true_ff   <= true_in;
         rvalid_ff <= emit || (rvalid_ff && !rsp.ready);
         if (exec && out_free) begin
            case (cur_ff.kind)
               KIND_BLOCK_START: begin
                  start_ff[0]  <= true_ff;
                  lstate_ff[0] <= true_ff;
                  for (int j = 1; j < LANES; j++) begin
                     start_ff[j]  <= (st_ok_q && cl_ok_q) ? guess_rd[j] : '0;
                     lstate_ff[j] <= (st_ok_q && cl_ok_q) ? guess_rd[j] : '0;
                  end
               end
               KIND_PAIR: begin
                  for (int j = 1; j < LANES; j++) lstate_ff[j] <= rd_data[j];
                  lstate_ff[0] <= cur_ff.block_end ? true_in : rd_data[0];
               end
               KIND_SINGLE: lstate_ff[0] <= true_in;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff.state_out <= true_in;
         rsp_ff.spec_hit  <= cur_ff.kind == KIND_PAIR && hit_any;
         rsp_ff.hit_lane  <= (cur_ff.kind == KIND_PAIR && hit_any) ? LANE_W'(hit_idx) : '0;
      end
   end

   assign rsp.valid     = rvalid_ff;
   assign rsp.state_out = rsp_ff.state_out;
   assign rsp.spec_hit  = rsp_ff.spec_hit;
   assign rsp.hit_lane  = rsp_ff.hit_lane;

   `SDM_ASSERT_IMP(a_phase, clock, reset, 1'b1, $onehot(phase_ff), "phase not one-hot")
   `SDM_ASSERT_NEXT(a_emit, clock, reset, emit, rsp.valid, "response lost")
   `SDM_ASSERT_IMP(a_hit, clock, reset, rsp.valid && !rsp.spec_hit, rsp.hit_lane == '0,
      "lane without hit")
endmodule

// ===== verif/tb_speculative_dfa_stream_matcher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_speculative_dfa_stream_matcher_top
// Self-checking bench for the speculative DFA stream matcher. The bench loads
// a class map that uses only four classes, and keeps every loaded state among
// eight favored states, so transitions for those classes and states plus
// every guess entry for them mean no lookup ever touches an unwritten entry.
// It then runs directed and random block, pair and single requests with table
// reloads mixed in. A scoreboard predicts each response and compares it field
// by field. Sender bursts, receiver stalls and one long receiver hold-off
// exercise the handshakes.
// ----------------------------------------------------------------------------
module tb_speculative_dfa_stream_matcher_top;
   import sdm_pkg::*;

   localparam logic [2:0] KIND_SPARE_6 = 3'd6;
   localparam logic [2:0] KIND_SPARE_7 = 3'd7;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 450;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AT      = 800;

   typedef struct {
      logic [2:0] kind;
      logic [7:0] index_state;
      logic [5:0] class_a;
      logic [5:0] class_b;
      logic [3:0] lane;
      logic [7:0] value_state;
      logic [7:0] byte_value;
      logic [7:0] sym_first;
      logic [7:0] sym_second;
      logic       block_end;
   } request_type;

   // classes the class map may use, and the only states loads ever write
   logic [5:0] used_class [4] = '{6'd0, 6'd21, 6'd42, 6'd63};
   logic [7:0] hot_state  [8] = '{8'h00, 8'h01, 8'h55, 8'hAA, 8'h7F, 8'h80, 8'hFE, 8'hFF};

   // Scoreboard: predicts matcher responses and checks them in order
   class match_scoreboard;
      logic [7:0] trans_tab [64][256];
      logic [5:0] class_tab [256];
      logic [7:0] guess_tab [64][64][16];
      logic [7:0] true_state;
      logic [7:0] lane_start [16];
      logic [7:0] lane_state [16];
      rsp_type    expected_q [$];
      int         errors;
      int         checked;
      int         hits;

      function new();
         true_state = '0;
         foreach (lane_start[j]) begin
            lane_start[j] = '0;
            lane_state[j] = '0;
         end
         errors  = 0;
         checked = 0;
         hits    = 0;
      endfunction

      function void note_request(request_type r);
         logic [5:0] ca;
         logic [5:0] cb;
         logic [3:0] hit;
         rsp_type    rs;
         hit = '0;
         case (r.kind)
            KIND_LOAD_TRANS: trans_tab[r.class_a][r.index_state] = r.value_state;
            KIND_LOAD_CLASS: class_tab[r.byte_value] = r.class_a;
            KIND_LOAD_GUESS: begin
               if (r.lane != 0) guess_tab[r.class_a][r.class_b][r.lane] = r.value_state;
            end
            KIND_BLOCK_START: begin
               ca = class_tab[r.sym_first];
               cb = class_tab[r.sym_second];
               lane_start[0] = true_state;
               lane_state[0] = true_state;
               for (int j = 1; j < 16; j++) begin
                  lane_start[j] = guess_tab[ca][cb][j];
                  lane_state[j] = lane_start[j];
               end
            end
            KIND_PAIR: begin
               ca = class_tab[r.sym_first];
               cb = class_tab[r.sym_second];
               lane_state[0] = trans_tab[ca][lane_state[0]];
               for (int j = 1; j < 16; j++) lane_state[j] = trans_tab[cb][lane_state[j]];
               if (r.block_end) begin
                  // lowest guess lane whose start equals lane 0's end state
                  for (int j = 1; j < 16; j++)
                     if (hit == 0 && lane_start[j] == lane_state[0]) hit = 4'(j);
                  true_state = (hit != 0) ? lane_state[hit] : lane_state[0];
                  lane_state[0] = true_state;
                  rs.state_out = true_state;
                  rs.spec_hit  = (hit != 0);
                  rs.hit_lane  = hit;
                  expected_q.push_back(rs);
               end
            end
            KIND_SINGLE: begin
               true_state = trans_tab[class_tab[r.sym_first]][true_state];
               lane_state[0] = true_state;
               rs.state_out = true_state;
               rs.spec_hit  = 1'b0;
               rs.hit_lane  = '0;
               expected_q.push_back(rs);
            end
            default: ;
         endcase
      endfunction

      task report(string what, int got, int want);
         $display("mismatch: %s got %0d expected %0d (response %0d)", what, got, want, checked);
         errors++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report("unexpected response, state_out", got.state_out, -1);
            return;
         end
         want = expected_q.pop_front();
         if (got.state_out !== want.state_out) report("state_out", got.state_out, want.state_out);
         if (got.spec_hit !== want.spec_hit) report("spec_hit", got.spec_hit, want.spec_hit);
         if (got.hit_lane !== want.hit_lane) report("hit_lane", got.hit_lane, want.hit_lane);
         if (want.spec_hit) hits++;
         checked++;
      endtask
   endclass

   logic clock;
   logic reset;
   int   cycles;
   int   burst_left;
   int   sent;
   bit   hold_off_req;
   match_scoreboard board;

   sdm_req_if req ();
   sdm_rsp_if rsp ();

   speculative_dfa_stream_matcher_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // response check at the rising edge
   always @(posedge clock) begin
      rsp_type r;
      if (!reset && rsp.valid && rsp.ready) begin
         r.state_out = rsp.state_out;
         r.spec_hit  = rsp.spec_hit;
         r.hit_lane  = rsp.hit_lane;
         board.check_response(r);
      end
   end

   // receiver: stall mode changes every stretch, plus one long hold-off
   initial begin
      int mode;
      rsp.ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         for (int k = 0; k < 64; k++) begin
            @(negedge clock);
            if (hold_off_req) begin
               rsp.ready = 1'b0;
               for (int h = 0; h < HOLD_CYCLES; h++) @(negedge clock);
               hold_off_req = 1'b0;
            end
            case (mode)
               0: rsp.ready = 1'b1;
               1: rsp.ready = ($urandom_range(0, 9) < 7);
               2: rsp.ready = (k % 4 == 0);
               default: rsp.ready = ($urandom_range(0, 9) < 2);
            endcase
         end
      end
   end

   function automatic request_type noise_request(logic [2:0] kind);
      request_type r;
      r.kind        = kind;
      r.index_state = 8'($urandom);
      r.class_a     = 6'($urandom);
      r.class_b     = 6'($urandom);
      r.lane        = 4'($urandom);
      r.value_state = 8'($urandom);
      r.byte_value  = 8'($urandom);
      r.sym_first   = 8'($urandom);
      r.sym_second  = 8'($urandom);
      r.block_end   = 1'($urandom);
      return r;
   endfunction

   function automatic logic [7:0] pick_state();
      return hot_state[$urandom_range(0, 7)];
   endfunction

   // drive one request at the falling edge and wait for the handshake
   task automatic send(request_type r);
      @(negedge clock);
      req.valid       = 1'b1;
      req.kind        = r.kind;
      req.index_state = r.index_state;
      req.class_a     = r.class_a;
      req.class_b     = r.class_b;
      req.lane        = r.lane;
      req.value_state = r.value_state;
      req.byte_value  = r.byte_value;
      req.sym_first   = r.sym_first;
      req.sym_second  = r.sym_second;
      req.block_end   = r.block_end;
      do @(posedge clock); while (!req.ready);
      board.note_request(r);
      sent++;
      if (sent == HOLD_AT) hold_off_req = 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         if (!hold_off_req) begin
            @(negedge clock);
            req.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   task automatic send_trans(logic [5:0] c, logic [7:0] s, logic [7:0] v);
      request_type r;
      r = noise_request(KIND_LOAD_TRANS);
      r.class_a = c;
      r.index_state = s;
      r.value_state = v;
      send(r);
   endtask

   task automatic send_class(logic [7:0] b, logic [5:0] c);
      request_type r;
      r = noise_request(KIND_LOAD_CLASS);
      r.byte_value = b;
      r.class_a = c;
      send(r);
   endtask

   task automatic send_guess(logic [5:0] ca, logic [5:0] cb, logic [3:0] ln, logic [7:0] v);
      request_type r;
      r = noise_request(KIND_LOAD_GUESS);
      r.class_a = ca;
      r.class_b = cb;
      r.lane = ln;
      r.value_state = v;
      send(r);
   endtask

   task automatic send_single(logic [7:0] b);
      request_type r;
      r = noise_request(KIND_SINGLE);
      r.sym_first = b;
      send(r);
   endtask

   task automatic send_start(logic [7:0] b1, logic [7:0] b2);
      request_type r;
      r = noise_request(KIND_BLOCK_START);
      r.sym_first = b1;
      r.sym_second = b2;
      send(r);
   endtask

   task automatic send_pair(logic [7:0] b1, logic [7:0] b2, logic last);
      request_type r;
      r = noise_request(KIND_PAIR);
      r.sym_first = b1;
      r.sym_second = b2;
      r.block_end = last;
      send(r);
   endtask

   // block start followed by a run of pairs, the last one closing the block
   task automatic send_block(int pairs);
      send_start(8'($urandom), 8'($urandom));
      for (int p = 1; p <= pairs; p++) send_pair(8'($urandom), 8'($urandom), p == pairs);
   endtask

   initial begin
      int choice;
      board        = new();
      cycles       = 0;
      sent         = 0;
      burst_left   = 10;
      hold_off_req = 1'b0;
      reset        = 1'b1;
      req.valid       = 1'b0;
      req.kind        = KIND_SINGLE;
      req.index_state = '0;
      req.class_a     = '0;
      req.class_b     = '0;
      req.lane        = '0;
      req.value_state = '0;
      req.byte_value  = '0;
      req.sym_first   = '0;
      req.sym_second  = '0;
      req.block_end   = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // table setup: every lookup the stimulus can cause is defined
      for (int b = 0; b < 256; b++) send_class(8'(b), used_class[$urandom_range(0, 3)]);
      foreach (used_class[c])
         foreach (hot_state[s]) send_trans(used_class[c], hot_state[s], pick_state());
      foreach (used_class[a])
         foreach (used_class[b])
            for (int ln = 1; ln < 16; ln++)
               send_guess(used_class[a], used_class[b], 4'(ln), pick_state());

      // directed: extremes, ignored kinds, bad guess lane, pairs without start
      send_single(8'h00);
      send_single(8'hFF);
      send_pair(8'h00, 8'hFF, 1'b1);
      send_pair(8'hFF, 8'h00, 1'b0);
      send_pair(8'h5A, 8'hA5, 1'b1);
      send_start(8'h00, 8'h00);
      send_pair(8'hFF, 8'hFF, 1'b1);
      send_start(8'hFF, 8'hFF);
      send_pair(8'h00, 8'h00, 1'b0);
      send_pair(8'h7F, 8'h80, 1'b1);
      send(noise_request(KIND_SPARE_6));
      send(noise_request(KIND_SPARE_7));
      send_guess(used_class[0], used_class[3], 4'd0, 8'hFF);
      send_start(8'h00, 8'hFF);
      send_block(1);
      send_trans(6'd63, 8'hFF, 8'h00);
      send_trans(6'd0, 8'h00, 8'hFF);
      send_class(8'hFF, 6'd63);
      send_guess(6'd63, 6'd63, 4'd15, 8'hFF);
      send_block(3);
      send_single(8'h80);

      // random: mostly well-formed blocks, with singles, reloads and noise
      for (int n = 0; n < RANDOM_ITEMS; ) begin
         choice = $urandom_range(0, 99);
         if (choice < 55) begin
            choice = $urandom_range(1, 6);
            send_block(choice);
            n += choice + 1;
         end else begin
            if (choice < 75) send_single(8'($urandom));
            else if (choice < 80) send_pair(8'($urandom), 8'($urandom), 1'($urandom));
            else if (choice < 85) send_trans(6'($urandom), 8'($urandom), pick_state());
            else if (choice < 89) send_class(8'($urandom), used_class[$urandom_range(0, 3)]);
            else if (choice < 95)
               send_guess(6'($urandom), 6'($urandom), 4'($urandom), pick_state());
            else send(noise_request($urandom_range(0, 1) ? KIND_SPARE_6 : KIND_SPARE_7));
            n++;
         end
      end
      @(negedge clock);
      req.valid = 1'b0;

      // drain and let the engine settle
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("sent %0d requests, checked %0d responses, %0d speculative hits",
               sent, board.checked, board.hits);
      $display("covered table loads, blocks with guess lanes, tail singles and ignored kinds");
      if (board.errors == 0 && board.expected_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
